FILE: src/rgb_led_pulse_encoder_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the pulse encoder RTL
// ---------------------------------------------------------------------------
`ifndef RGB_LED_PULSE_ENCODER_CORE_DEFINES_SVH
`define RGB_LED_PULSE_ENCODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpe: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpe: next-cycle check failed");

`endif

FILE: src/rlpe_pkg.sv
// ---------------------------------------------------------------------------
// rlpe_pkg
// Types and constants of the single-wire RGB LED pulse encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlpe_pkg;

    localparam int WORD_BITS   = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);

    localparam logic [8:0] FULL_SCALE = 9'd256;

    // configuration register indexes
    localparam logic [2:0] CFG_BRIGHTNESS    = 3'd0;
    localparam logic [2:0] CFG_ONE_HIGH_LEN  = 3'd1;
    localparam logic [2:0] CFG_ONE_LOW_LEN   = 3'd2;
    localparam logic [2:0] CFG_ZERO_HIGH_LEN = 3'd3;
    localparam logic [2:0] CFG_ZERO_LOW_LEN  = 3'd4;
    localparam logic [2:0] CFG_RESET_GAP_LEN = 3'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic        line_level;
        logic [15:0] duration;
        logic        is_gap;
        logic        last_segment;
    } segment_t;

    // scaled GRB word handed from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last_pixel;
    } word_item_t;

    // segment timing registers used by the serialiser
    typedef struct packed {
        logic [9:0]  one_high_len;
        logic [9:0]  one_low_len;
        logic [9:0]  zero_high_len;
        logic [9:0]  zero_low_len;
        logic [15:0] reset_gap_len;
    } timing_cfg_t;

endpackage

`default_nettype wire

FILE: src/rgb_led_pulse_encoder_core.sv
// A pixel passes the front register, the word queue and the serialiser state
// before its first segment. One segment per cycle while segment_stall is low; the
// serialiser starts the next queued word behind the final segment.
// Reset: rst_n clears all control state and loads the register reset values;
// no clearing pass, the block takes pixels in the first cycle after reset.
// ---------------------------------------------------------------------------
// rgb_led_pulse_encoder_core
// Top level: configuration registers, front scaler, word queue, serialiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pulse_encoder_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pixel_valid,
    output logic                    pixel_stall,
    input  wire rlpe_pkg::pixel_t   pixel,
    output logic                    segment_valid,
    input  wire logic               segment_stall,
    output rlpe_pkg::segment_t      segment,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    logic [8:0]            brightness_reg;
    rlpe_pkg::timing_cfg_t timing_reg;
    logic                  q_full;
    logic                  push;
    rlpe_pkg::word_item_t  push_item;
    logic                  pop;
    logic                  head_valid;
    rlpe_pkg::word_item_t  head_item;

    assign cfg_ready = 1'b1;

    // unknown indexes drop the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg           <= 9'd256;
            timing_reg.one_high_len  <= 10'd11;
            timing_reg.one_low_len   <= 10'd3;
            timing_reg.zero_high_len <= 10'd4;
            timing_reg.zero_low_len  <= 10'd11;
            timing_reg.reset_gap_len <= 16'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rlpe_pkg::CFG_BRIGHTNESS:    brightness_reg           <= cfg_data[8:0];
                rlpe_pkg::CFG_ONE_HIGH_LEN:  timing_reg.one_high_len  <= cfg_data[9:0];
                rlpe_pkg::CFG_ONE_LOW_LEN:   timing_reg.one_low_len   <= cfg_data[9:0];
                rlpe_pkg::CFG_ZERO_HIGH_LEN: timing_reg.zero_high_len <= cfg_data[9:0];
                rlpe_pkg::CFG_ZERO_LOW_LEN:  timing_reg.zero_low_len  <= cfg_data[9:0];
                rlpe_pkg::CFG_RESET_GAP_LEN: timing_reg.reset_gap_len <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rlpe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .brightness  (brightness_reg),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    rlpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    rlpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .timing        (timing_reg),
        .segment_valid (segment_valid),
        .segment_stall (segment_stall),
        .segment       (segment)
    );

endmodule

`default_nettype wire

FILE: src/rlpe_front.sv
// ---------------------------------------------------------------------------
// rlpe_front
// Takes pixel requests, scales each colour by brightness, packs GRB.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlpe_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pixel_valid,
    output logic                     pixel_stall,
    input  wire rlpe_pkg::pixel_t    pixel,
    input  wire logic [8:0]          brightness,
    input  wire logic                q_full,
    output logic                     push,
    output rlpe_pkg::word_item_t     push_item
);

    logic                 f_valid_reg;
    logic                 f_valid_next;
    rlpe_pkg::word_item_t f_item_reg;
    rlpe_pkg::word_item_t f_item_next;
    logic [8:0]           factor;
    logic [16:0]          prod_r;
    logic [16:0]          prod_g;
    logic [16:0]          prod_b;
    logic                 take;

    // anything above full scale saturates to full
    assign factor = brightness[8] ? rlpe_pkg::FULL_SCALE : brightness;

    assign prod_r = {9'd0, pixel.red}   * {8'd0, factor};
    assign prod_g = {9'd0, pixel.green} * {8'd0, factor};
    assign prod_b = {9'd0, pixel.blue}  * {8'd0, factor};

    assign push        = f_valid_reg && !q_full;
    assign pixel_stall = f_valid_reg && q_full;
    assign take        = pixel_valid && !pixel_stall;
    assign push_item   = f_item_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (take)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
        f_item_next.word       = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
        f_item_next.last_pixel = pixel.last_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/rlpe_queue.sv
// ---------------------------------------------------------------------------
// rlpe_queue
// Short FIFO of packed words between the front and the serialiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_led_pulse_encoder_core_defines.svh"

module rlpe_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rlpe_pkg::word_item_t push_item,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      head_valid,
    output rlpe_pkg::word_item_t      head_item
);

    localparam int PTR_W = $clog2(rlpe_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rlpe_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(rlpe_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(rlpe_pkg::QUEUE_DEPTH - 1);

    rlpe_pkg::word_item_t entry_reg [rlpe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `RLPE_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, head_valid)
    `RLPE_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
    `RLPE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)

endmodule

`default_nettype wire

FILE: src/rlpe_back.sv
// ---------------------------------------------------------------------------
// rlpe_back
// Serialiser: turns each packed word into high/low segments and latch gap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_led_pulse_encoder_core_defines.svh"

module rlpe_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire rlpe_pkg::word_item_t  head_item,
    output logic                       pop,
    input  wire rlpe_pkg::timing_cfg_t timing,
    output logic                       segment_valid,
    input  wire logic                  segment_stall,
    output rlpe_pkg::segment_t         segment
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HIGH = 2'd1;
    localparam logic [1:0] ST_LOW  = 2'd2;
    localparam logic [1:0] ST_GAP  = 2'd3;

    localparam int IDX_W = rlpe_pkg::BIT_IDX_W;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(rlpe_pkg::WORD_BITS - 1);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [rlpe_pkg::WORD_BITS-1:0]  word_reg;
    logic [rlpe_pkg::WORD_BITS-1:0]  word_next;
    logic                            last_reg;
    logic                            last_next;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                idx_next;
    logic                            seg_valid_reg;
    logic                            seg_valid_next;
    rlpe_pkg::segment_t              seg_reg;
    rlpe_pkg::segment_t              seg_next;
    logic                            advance;
    logic                            busy;
    logic                            finishing;
    logic                            bit_one;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        at_least_one = (v == 16'd0) ? 16'd1 : v;
    endfunction

    assign advance   = !seg_valid_reg || !segment_stall;
    assign busy      = (state_reg != ST_IDLE);
    assign bit_one   = word_reg[rlpe_pkg::WORD_BITS-1];
    assign finishing = (state_reg == ST_GAP)
                    || (state_reg == ST_LOW && idx_reg == '0 && !last_reg);
    assign pop       = advance && head_valid && (!busy || finishing);

    assign segment_valid = seg_valid_reg;
    assign segment       = seg_reg;

    // segment for the current state
    always_comb
    begin
        seg_next = '0;
        unique case (state_reg)
            ST_HIGH:
            begin
                seg_next.line_level = 1'b1;
                seg_next.duration   = at_least_one({6'd0, bit_one ? timing.one_high_len
                                                                 : timing.zero_high_len});
            end
            ST_LOW:
            begin
                seg_next.duration     = at_least_one({6'd0, bit_one ? timing.one_low_len
                                                                   : timing.zero_low_len});
                seg_next.last_segment = (idx_reg == '0) && !last_reg;
            end
            ST_GAP:
            begin
                seg_next.duration     = at_least_one(timing.reset_gap_len);
                seg_next.is_gap       = 1'b1;
                seg_next.last_segment = 1'b1;
            end
            default:
            begin
                seg_next = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        seg_valid_next = seg_valid_reg;
        if (advance)
        begin
            seg_valid_next = busy;
            unique case (state_reg)
                ST_HIGH:
                begin
                    state_next = ST_LOW;
                end
                ST_LOW:
                begin
                    if (idx_reg != '0)
                    begin
                        state_next = ST_HIGH;
                        word_next  = {word_reg[rlpe_pkg::WORD_BITS-2:0], 1'b0};
                        idx_next   = idx_reg - 1'b1;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_GAP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_GAP:
                begin
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
            // load the next word straight behind the final segment
            if (pop)
            begin
                state_next = ST_HIGH;
                word_next  = head_item.word;
                last_next  = head_item.last_pixel;
                idx_next   = TOP_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_valid_reg <= seg_valid_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (advance && busy)
        begin
            seg_reg <= seg_next;
        end
    end

    `RLPE_ASSERT_NOW(a_gap_on_last_bit, clk, rst_n, state_reg == ST_GAP,
        idx_reg == '0 && last_reg)
    `RLPE_ASSERT_NEXT(a_high_then_low, clk, rst_n, advance && state_reg == ST_HIGH,
        state_reg == ST_LOW && segment_valid && segment.line_level)
    `RLPE_ASSERT_NOW(a_gap_shape, clk, rst_n, segment_valid && segment.is_gap,
        segment.last_segment && !segment.line_level)

endmodule

`default_nettype wire

FILE: tb/sv/rgb_led_pulse_encoder_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_led_pulse_encoder_core_test
// Self-checking bench for the pulse encoder: walks a directed table, then
// runs random pixels under random timing registers. Every line segment
// is predicted at pixel acceptance and checked field by field.
// ---------------------------------------------------------------------------

module rgb_led_pulse_encoder_core_test;

    localparam int DIRECTED_ROWS    = 15;
    localparam int RANDOM_PHASES    = 6;
    localparam int PIXELS_PER_PHASE = 20;
    localparam int LONG_HOLD        = 400;
    localparam int NO_WRITE         = -1;

    typedef struct packed {
        logic [15:0] brightness;
        logic [15:0] one_high;
        logic [15:0] one_low;
        logic [15:0] zero_high;
        logic [15:0] zero_low;
        logic [15:0] gap;
    } reg_set_t;

    typedef struct {
        int               setting;
        rlpe_pkg::pixel_t px;
        bit               known;
        logic [23:0]      grb;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               pixel_valid;
    logic               pixel_stall;
    rlpe_pkg::pixel_t   pixel;
    logic               segment_valid;
    logic               segment_stall;
    rlpe_pkg::segment_t segment;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    // register copies used by the predictor
    logic [8:0]  brightness_q;
    logic [9:0]  one_high_q;
    logic [9:0]  one_low_q;
    logic [9:0]  zero_high_q;
    logic [9:0]  zero_low_q;
    logic [15:0] gap_q;

    rlpe_pkg::segment_t segments_due [$];
    rlpe_pkg::segment_t want_seg;
    int       errors = 0;
    bit       calm = 1'b0;
    int       holds_asked = 0;
    int       holds_done;
    int       stall_left;

    // brightness 0 with zero lengths; saturating brightness with masked data;
    // just above full; half; near-zero; 255 with reset timing
    reg_set_t reg_sets [6] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'h03FF, 16'hFC01, 16'h0400, 16'hFFFF},
        '{16'd257,  16'd1,    16'd1,    16'd1,    16'd1,    16'd1},
        '{16'd128,  16'd7,    16'd2,    16'd3,    16'd9,    16'd300},
        '{16'd1,    16'd1023, 16'd1,    16'd1,    16'd1023, 16'd2},
        '{16'd255,  16'd11,   16'd3,    16'd4,    16'd11,   16'd50}
    };

    // pixel fields: red, green, blue, last_pixel; grb typed where obvious
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{NO_WRITE, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 24'h000000},
        '{NO_WRITE, '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, 24'hFFFFFF},
        '{NO_WRITE, '{8'hFF, 8'h00, 8'h00, 1'b0}, 1'b1, 24'h00FF00},
        '{NO_WRITE, '{8'h00, 8'hFF, 8'h00, 1'b1}, 1'b1, 24'hFF0000},
        '{NO_WRITE, '{8'h00, 8'h00, 8'hFF, 1'b0}, 1'b1, 24'h0000FF},
        '{NO_WRITE, '{8'hA5, 8'h5A, 8'h3C, 1'b1}, 1'b1, 24'h5AA53C},
        '{0,        '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, 24'h000000},
        '{NO_WRITE, '{8'h80, 8'h01, 8'h7F, 1'b0}, 1'b1, 24'h000000},
        '{1,        '{8'hFF, 8'h00, 8'h81, 1'b1}, 1'b1, 24'h00FF81},
        '{NO_WRITE, '{8'h12, 8'h34, 8'h56, 1'b0}, 1'b1, 24'h341256},
        '{2,        '{8'h01, 8'hFE, 8'h80, 1'b1}, 1'b1, 24'hFE0180},
        '{3,        '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b0, 24'h000000},
        '{NO_WRITE, '{8'h01, 8'h02, 8'h03, 1'b0}, 1'b0, 24'h000000},
        '{4,        '{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, 24'h000000},
        '{5,        '{8'hFF, 8'h80, 8'h01, 1'b1}, 1'b0, 24'h000000}
    };

    rgb_led_pulse_encoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .segment_valid (segment_valid),
        .segment_stall (segment_stall),
        .segment       (segment),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] scale_channel(input logic [7:0] c);
        logic [8:0]  f;
        logic [16:0] prod;
        f = (brightness_q > rlpe_pkg::FULL_SCALE) ? rlpe_pkg::FULL_SCALE : brightness_q;
        prod = c * f;
        return prod[15:8];
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'h03FF;
            3: return 16'hFFFF;
            4: return 16'($urandom);
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rlpe_pkg::CFG_BRIGHTNESS:    brightness_q = val[8:0];
            rlpe_pkg::CFG_ONE_HIGH_LEN:  one_high_q   = val[9:0];
            rlpe_pkg::CFG_ONE_LOW_LEN:   one_low_q    = val[9:0];
            rlpe_pkg::CFG_ZERO_HIGH_LEN: zero_high_q  = val[9:0];
            rlpe_pkg::CFG_ZERO_LOW_LEN:  zero_low_q   = val[9:0];
            rlpe_pkg::CFG_RESET_GAP_LEN: gap_q        = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input reg_set_t s);
        // an index past the last register must be dropped
        write_reg(rlpe_pkg::CFG_RESET_GAP_LEN + 3'd1 + 3'($urandom_range(0, 1)),
                  16'($urandom));
        write_reg(rlpe_pkg::CFG_BRIGHTNESS, s.brightness);
        write_reg(rlpe_pkg::CFG_ONE_HIGH_LEN, s.one_high);
        write_reg(rlpe_pkg::CFG_ONE_LOW_LEN, s.one_low);
        write_reg(rlpe_pkg::CFG_ZERO_HIGH_LEN, s.zero_high);
        write_reg(rlpe_pkg::CFG_ZERO_LOW_LEN, s.zero_low);
        write_reg(rlpe_pkg::CFG_RESET_GAP_LEN, s.gap);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (segments_due.size() != 0)
            @(posedge clk);
    endtask

    // offer one pixel, then queue the 48 or 49 segments it must produce
    task automatic send_pixel(input rlpe_pkg::pixel_t px, input bit known,
                              input logic [23:0] grb);
        logic [23:0] word;
        logic [9:0]  hi;
        logic [9:0]  lo;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        word = known ? grb : {scale_channel(px.green), scale_channel(px.red),
                              scale_channel(px.blue)};
        for (int b = rlpe_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            hi = word[b] ? one_high_q : zero_high_q;
            lo = word[b] ? one_low_q : zero_low_q;
            segments_due.push_back(rlpe_pkg::segment_t'{1'b1,
                (hi == 10'd0) ? 16'd1 : {6'd0, hi}, 1'b0, 1'b0});
            segments_due.push_back(rlpe_pkg::segment_t'{1'b0,
                (lo == 10'd0) ? 16'd1 : {6'd0, lo}, 1'b0, (b == 0) && !px.last_pixel});
        end
        if (px.last_pixel)
            segments_due.push_back(rlpe_pkg::segment_t'{1'b0,
                (gap_q == 16'd0) ? 16'd1 : gap_q, 1'b1, 1'b1});
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_stall <= 1'b0;
            stall_left    <= 0;
            holds_done    <= 0;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done    <= holds_done + 1;
            stall_left    <= LONG_HOLD - 1;
            segment_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            segment_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 13);
            segment_stall <= 1'b1;
        end
        else
            segment_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && segment_valid && !segment_stall)
        begin
            if (segments_due.size() == 0)
            begin
                $display("%0t: segment expected none got %p", $time, segment);
                errors++;
            end
            else
            begin
                want_seg = segments_due.pop_front();
                if (segment.line_level !== want_seg.line_level)
                begin
                    $display("%0t: line_level expected %0d got %0d", $time,
                             want_seg.line_level, segment.line_level);
                    errors++;
                end
                if (segment.duration !== want_seg.duration)
                begin
                    $display("%0t: duration expected %0d got %0d", $time,
                             want_seg.duration, segment.duration);
                    errors++;
                end
                if (segment.is_gap !== want_seg.is_gap)
                begin
                    $display("%0t: is_gap expected %0d got %0d", $time,
                             want_seg.is_gap, segment.is_gap);
                    errors++;
                end
                if (segment.last_segment !== want_seg.last_segment)
                begin
                    $display("%0t: last_segment expected %0d got %0d", $time,
                             want_seg.last_segment, segment.last_segment);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        reg_set_t         rs;
        rlpe_pkg::pixel_t px;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        brightness_q = 9'd256;
        one_high_q   = 10'd11;
        one_low_q    = 10'd3;
        zero_high_q  = 10'd4;
        zero_low_q   = 10'd11;
        gap_q        = 16'd50;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].setting != NO_WRITE)
            begin
                pixel_valid <= 1'b0;
                wait_drained();
                load_regs(reg_sets[directed_rows[i].setting]);
            end
            send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].grb);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            pixel_valid <= 1'b0;
            wait_drained();
            case ($urandom_range(0, 4))
                0: rs.brightness = 16'd0;
                1: rs.brightness = 16'd256;
                2: rs.brightness = 16'($urandom_range(257, 511));
                3: rs.brightness = 16'($urandom);
                default: rs.brightness = 16'($urandom_range(1, 255));
            endcase
            rs.one_high  = pick_len();
            rs.one_low   = pick_len();
            rs.zero_high = pick_len();
            rs.zero_low  = pick_len();
            rs.gap       = pick_len();
            load_regs(rs);
            // hold the output long enough to back the pipeline up
            if (ph == 1)
                holds_asked <= holds_asked + 1;
            if (ph == RANDOM_PHASES - 1)
                calm <= 1'b1;
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                px.red        = pick_byte();
                px.green      = pick_byte();
                px.blue       = pick_byte();
                px.last_pixel = ($urandom_range(0, 3) == 0);
                send_pixel(px, 1'b0, 24'd0);
            end
        end

        pixel_valid <= 1'b0;
        wait_drained();
        repeat (12)
            @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
